// ===== src/pcuf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcuf_pkg
// Shared constants and controller/datapath interface types for the
// per-colour union-find core.
// ----------------------------------------------------------------------------
package pcuf_pkg;

   localparam int NODES_DEFAULT  = 128;
   localparam int COLORS_DEFAULT = 128;

   localparam int NODE_FIELD_W  = 7;
   localparam int COLOR_FIELD_W = 7;
   localparam int COUNT_W       = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_COUNT = 3'd0;
   localparam logic [COUNT_W-1:0]    COLOR_COUNT_RESET = 8'd128;

   typedef struct packed {
      logic clear;
      logic load;
      logic begin_find;
      logic find_sel_b;
      logic chk;
      logic cmp_wr;
      logic save_ra;
      logic union_wr;
      logic count;
      logic next_color;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic add_ok;
      logic query_ok;
      logic rd_eq_cur;
      logic cur_eq_root;
      logic last_color;
      logic rsp_free;
   } status_type;

endpackage

// ===== src/pcuf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcuf_ctrl
// Sequencer: clearing pass, find with path compression, union and the
// per-colour query loop.
// ----------------------------------------------------------------------------
module pcuf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   input  pcuf_pkg::status_type status,
   output pcuf_pkg::cmd_type    cmd,
   output logic                 busy
);
   import pcuf_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FRD   = 3'd2;
   localparam logic [2:0] S_FCHK  = 3'd3;
   localparam logic [2:0] S_CRD   = 3'd4;
   localparam logic [2:0] S_CWR   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       phase_b_ff, phase_b_in;
   logic       op_ff, op_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      phase_b_in = phase_b_ff;
      op_in      = op_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               op_in      = req_op;
               phase_b_in = 1'b0;
               if (req_op == OP_ADD) begin
                  if (status.add_ok) state_in = S_FRD;
               end else begin
                  state_in = status.query_ok ? S_FRD : S_FIN;
               end
            end
         end
         S_FRD: state_in = S_FCHK;
         S_FCHK: begin
            cmd.chk  = 1'b1;
            state_in = status.rd_eq_cur ? S_CRD : S_FRD;
         end
         S_CRD: begin
            if (!status.cur_eq_root) begin
               state_in = S_CWR;
            end else if (!phase_b_ff) begin
               // Root of node a is known; now find node b in the same colour.
               cmd.save_ra    = 1'b1;
               cmd.begin_find = 1'b1;
               cmd.find_sel_b = 1'b1;
               phase_b_in     = 1'b1;
               state_in       = S_FRD;
            end else if (op_ff == OP_ADD) begin
               cmd.union_wr = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.count  = 1'b1;
               phase_b_in = 1'b0;
               if (status.last_color) begin
                  state_in = S_FIN;
               end else begin
                  cmd.next_color = 1'b1;
                  cmd.begin_find = 1'b1;
                  state_in       = S_FRD;
               end
            end
         end
         S_CWR: begin
            cmd.cmp_wr = 1'b1;
            state_in   = S_CRD;
         end
         S_FIN: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         phase_b_ff <= 1'b0;
         op_ff      <= OP_ADD;
      end else begin
         state_ff   <= state_in;
         phase_b_ff <= phase_b_in;
         op_ff      <= op_in;
      end
   end

endmodule

// ===== src/pcuf_dp.sv =====
// ----------------------------------------------------------------------------
// pcuf_dp
// Datapath: parent table memory, walk pointers, query counter and the
// result register.
// ----------------------------------------------------------------------------
module pcuf_dp #(
   parameter int NODES  = pcuf_pkg::NODES_DEFAULT,
   parameter int COLORS = pcuf_pkg::COLORS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pcuf_pkg::cmd_type                 cmd,
   output pcuf_pkg::status_type              status,
   input  logic [pcuf_pkg::NODE_FIELD_W-1:0] req_node_a,
   input  logic [pcuf_pkg::NODE_FIELD_W-1:0] req_node_b,
   input  logic [pcuf_pkg::COLOR_FIELD_W-1:0] req_edge_color,
   input  logic                              req_op,
   input  logic [pcuf_pkg::COUNT_W-1:0]      color_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcuf_pkg::COUNT_W-1:0]      rsp_connected_colors
);
   import pcuf_pkg::*;

   localparam int NW    = $clog2(NODES);
   localparam int CW    = (COLORS > 1) ? $clog2(COLORS) : 1;
   localparam int AW    = NW + CW;
   localparam int DEPTH = 2 ** AW;

   logic [NW-1:0] mem [0:DEPTH-1];
   logic [NW-1:0] rdata_ff;

   logic [AW-1:0] clr_ff, clr_in;
   logic [NW-1:0] cur_ff, cur_in, start_ff, start_in, root_ff, root_in, ra_ff, ra_in;
   logic [NW-1:0] a_ff, a_in, b_ff, b_in;
   logic [CW-1:0] color_ff, color_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0] a32, b32, col32, lim32;
   logic [AW-1:0] raddr;

   assign a32   = 32'(req_node_a);
   assign b32   = 32'(req_node_b);
   assign col32 = 32'(req_edge_color);
   assign lim32 = (32'(color_count) < COLORS) ? 32'(color_count) : 32'(COLORS);
   assign raddr = {color_ff, cur_ff};

   assign status.clear_done  = (clr_ff == {AW{1'b1}});
   assign status.add_ok      = (a32 < NODES) && (b32 < NODES) && (col32 < COLORS);
   assign status.query_ok    = (a32 < NODES) && (b32 < NODES) && (color_count != '0);
   assign status.rd_eq_cur   = (rdata_ff == cur_ff);
   assign status.cur_eq_root = (cur_ff == root_ff);
   assign status.last_color  = ((32'(color_ff) + 32'd1) == lim32);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_connected_colors = rsp_data_ff;

   always_comb begin
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      start_in    = start_ff;
      root_in     = root_ff;
      ra_in       = ra_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      color_in    = color_ff;
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.clear) clr_in = clr_ff + 1'b1;
      if (cmd.load) begin
         a_in     = a32[NW-1:0];
         b_in     = b32[NW-1:0];
         cur_in   = a32[NW-1:0];
         start_in = a32[NW-1:0];
         color_in = (req_op == OP_ADD) ? col32[CW-1:0] : '0;
         count_in = '0;
      end
      if (cmd.chk) begin
         if (rdata_ff == cur_ff) begin
            root_in = cur_ff;
            cur_in  = start_ff;
         end else begin
            cur_in = rdata_ff;
         end
      end
      if (cmd.cmp_wr) cur_in = rdata_ff;
      if (cmd.save_ra) ra_in = root_ff;
      if (cmd.next_color) color_in = color_ff + 1'b1;
      if (cmd.begin_find) begin
         cur_in   = cmd.find_sel_b ? b_ff : a_ff;
         start_in = cmd.find_sel_b ? b_ff : a_ff;
      end
      if (cmd.count && (ra_ff == root_ff) && (count_ff != {COUNT_W{1'b1}}))
         count_in = count_ff + 1'b1;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (cmd.clear) begin
         mem[clr_ff] <= clr_ff[NW-1:0];
      end else if (cmd.cmp_wr) begin
         mem[raddr] <= root_ff;
      end else if (cmd.union_wr) begin
         mem[{color_ff, ra_ff}] <= root_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      root_ff     <= root_in;
      ra_ff       <= ra_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      color_ff    <= color_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/per_color_union_find_core.sv =====
// ----------------------------------------------------------------------------
// per_color_union_find_core
// One disjoint-set forest per edge colour, with union and connectivity count.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel is taken when req_valid is high and
// req_stall is low. An add-edge item unites node_a's and node_b's sets in
// edge_color and gives no result; a query item gives one rsp_ item, the
// number of colours (of the first color_count) in which the nodes connect.
// After reset a clearing pass writes every table entry, NODES x COLORS
// entries (16384 by default, rounded up to powers of two), with req_stall high.
// The block works on one item at a time. Each find step reads the table and
// then checks the parent that was read, and compressing rewrites each node on
// the walked path to the root and then closes. An add-edge takes two finds and
// a union write; a query takes two finds for every scanned colour.
// The result sits in an output register: a stalled result holds, and the next
// item is taken meanwhile; a following query waits only at its end.
// color_count is set at byte address 0 of the APB-style port.
// ----------------------------------------------------------------------------
module per_color_union_find_core #(
   parameter int NODES  = pcuf_pkg::NODES_DEFAULT,
   parameter int COLORS = pcuf_pkg::COLORS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [pcuf_pkg::NODE_FIELD_W-1:0]  req_node_a,
   input  logic [pcuf_pkg::NODE_FIELD_W-1:0]  req_node_b,
   input  logic [pcuf_pkg::COLOR_FIELD_W-1:0] req_edge_color,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pcuf_pkg::COUNT_W-1:0]       rsp_connected_colors,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pcuf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pcuf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pcuf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import pcuf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy;
   logic [COUNT_W-1:0] color_count_ff, color_count_in;

   assign pready    = 1'b1;
   assign req_stall = busy;
   assign prdata    = (paddr == REG_COLOR_COUNT) ? CSR_DATA_W'(color_count_ff) : '0;

   always_comb begin
      color_count_in = color_count_ff;
      if (psel && penable && pwrite && (paddr == REG_COLOR_COUNT))
         color_count_in = pwdata[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) color_count_ff <= COLOR_COUNT_RESET;
      else       color_count_ff <= color_count_in;
   end

   pcuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   pcuf_dp #(.NODES(NODES), .COLORS(COLORS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_node_a           (req_node_a),
      .req_node_b           (req_node_b),
      .req_edge_color       (req_edge_color),
      .req_op               (req_op),
      .color_count          (color_count_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_connected_colors (rsp_connected_colors)
   );

   // An add-edge never produces a result.
   a_add_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_op == OP_ADD)) |=> !$rose(rsp_valid))
      else $error("result raised after an add-edge item");

   // A result is only launched from the busy finishing step.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while the block was idle");

endmodule
